@@ rtl/nqsc_pkg.sv @@
package nqsc_pkg;

  localparam int BOARD_W     = 5;
  localparam int COLUMN_W    = 4;
  localparam int OUT_COUNT_W = 24;

  localparam logic [BOARD_W-1:0] BOARD_RESET = 5'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEARCH,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic init_final;
    logic search_last;
  } dp_status_t;

endpackage

@@ rtl/nqsc_datapath.sv @@
module nqsc_datapath #(
  parameter int MAX_BOARD  = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [nqsc_pkg::BOARD_W-1:0]        cfg_data,
  input  logic [nqsc_pkg::COLUMN_W-1:0]       first_column_in,
  input  nqsc_pkg::dp_cmd_t                   cmd,
  output nqsc_pkg::dp_status_t                status,
  output logic [nqsc_pkg::OUT_COUNT_W-1:0]    solution_count,
  output logic                                column_invalid
);
  import nqsc_pkg::*;

  localparam int IDX_W   = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int COL_W   = $clog2(MAX_BOARD + 1);
  localparam int DIAG_W  = 2 * MAX_BOARD;
  localparam int DIAG_IW = $clog2(DIAG_W);

  logic [BOARD_W-1:0]    board_size;
  logic [COL_W-1:0]      n_eff;
  logic [COLUMN_W-1:0]   first_col;
  logic                  invalid_flag;
  logic [MAX_BOARD-1:0]  col_mask;
  logic [DIAG_W-1:0]     up_mask;
  logic [DIAG_W-1:0]     down_mask;
  logic [IDX_W-1:0]      row;
  logic [COL_W-1:0]      trial;
  logic [COUNT_BITS-1:0] running_count;
  logic [IDX_W-1:0]      placed_columns [MAX_BOARD];

  logic [MAX_BOARD-1:0]  col_mask_next;
  logic [DIAG_W-1:0]     up_mask_next;
  logic [DIAG_W-1:0]     down_mask_next;
  logic [IDX_W-1:0]      row_next;
  logic [COL_W-1:0]      trial_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  place_write;

  logic                   col_off;
  logic                   first_off;
  logic                   trial_free;
  logic [IDX_W-1:0]       trial_idx;
  logic [IDX_W-1:0]       row_dec;
  logic [IDX_W-1:0]       back_col;
  logic [DIAG_IW-1:0]     up_idx;
  logic [DIAG_IW-1:0]     down_idx;
  logic [DIAG_IW-1:0]     back_up_idx;
  logic [DIAG_IW-1:0]     back_down_idx;
  logic [COL_W-1:0]       n_cfg;
  logic [OUT_COUNT_W-1:0] count_clip;

  // Effective board size: anything above the largest board acts as the largest board.
  assign n_cfg = (board_size > BOARD_W'(MAX_BOARD)) ? COL_W'(MAX_BOARD)
                                                    : COL_W'(board_size);

  assign first_off = ({1'b0, first_col} >= BOARD_W'(n_eff));
  assign status.init_final  = first_off || (n_eff == COL_W'(1));
  assign col_off            = (trial >= n_eff);
  assign status.search_last = col_off && (row == IDX_W'(1));

  assign trial_idx = trial[IDX_W-1:0];
  assign row_dec   = row - IDX_W'(1);
  assign back_col  = placed_columns[row_dec];

  // Diagonal indexes: row + column for one direction, row + (max - 1) - column for the other.
  assign up_idx        = DIAG_IW'(row) + DIAG_IW'(trial_idx);
  assign down_idx      = DIAG_IW'(row) + DIAG_IW'(MAX_BOARD - 1) - DIAG_IW'(trial_idx);
  assign back_up_idx   = DIAG_IW'(row_dec) + DIAG_IW'(back_col);
  assign back_down_idx = DIAG_IW'(row_dec) + DIAG_IW'(MAX_BOARD - 1) - DIAG_IW'(back_col);

  assign trial_free = !col_mask[trial_idx] && !up_mask[up_idx] && !down_mask[down_idx];

  always_comb begin
    col_mask_next  = col_mask;
    up_mask_next   = up_mask;
    down_mask_next = down_mask;
    row_next       = row;
    trial_next     = trial;
    count_next     = running_count;
    place_write    = 1'b0;
    if (col_off) begin
      // Row exhausted: lift the queen of the row above and move it one column on.
      row_next                      = row_dec;
      col_mask_next[back_col]       = 1'b0;
      up_mask_next[back_up_idx]     = 1'b0;
      down_mask_next[back_down_idx] = 1'b0;
      trial_next                    = COL_W'(back_col) + COL_W'(1);
    end else if (trial_free) begin
      place_write = 1'b1;
      if (COL_W'(row) == n_eff - COL_W'(1)) begin
        if (running_count != {COUNT_BITS{1'b1}}) begin
          count_next = running_count + COUNT_BITS'(1);
        end
        trial_next = trial + COL_W'(1);
      end else begin
        col_mask_next[trial_idx] = 1'b1;
        up_mask_next[up_idx]     = 1'b1;
        down_mask_next[down_idx] = 1'b1;
        row_next                 = row + IDX_W'(1);
        trial_next               = '0;
      end
    end else begin
      trial_next = trial + COL_W'(1);
    end
  end

  generate
    if (COUNT_BITS > OUT_COUNT_W) begin : g_clip
      assign count_clip = (|running_count[COUNT_BITS-1:OUT_COUNT_W]) ? {OUT_COUNT_W{1'b1}}
                                                                      : running_count[OUT_COUNT_W-1:0];
    end else begin : g_extend
      assign count_clip = OUT_COUNT_W'(running_count);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size    <= BOARD_RESET;
      row           <= '0;
      trial         <= '0;
      running_count <= '0;
    end else begin
      if (cfg_write) begin
        board_size <= cfg_data;
      end
      if (cmd.init) begin
        row           <= IDX_W'(1);
        trial         <= '0;
        running_count <= (!first_off && n_eff == COL_W'(1)) ? COUNT_BITS'(1) : '0;
      end else if (cmd.step) begin
        row           <= row_next;
        trial         <= trial_next;
        running_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_col <= first_column_in;
      n_eff     <= n_cfg;
    end
    if (cmd.init) begin
      invalid_flag <= first_off;
      // Only the first-row queen is marked when a search starts.
      col_mask     <= MAX_BOARD'(1) << first_col[IDX_W-1:0];
      up_mask      <= DIAG_W'(1) << first_col[IDX_W-1:0];
      down_mask    <= DIAG_W'(1) <<
                      (DIAG_IW'(MAX_BOARD - 1) - DIAG_IW'(first_col[IDX_W-1:0]));
    end else if (cmd.step) begin
      col_mask  <= col_mask_next;
      up_mask   <= up_mask_next;
      down_mask <= down_mask_next;
    end
    if (cmd.step && place_write) begin
      placed_columns[row] <= trial_idx;
    end
    if (cmd.emit) begin
      solution_count <= count_clip;
      column_invalid <= invalid_flag;
    end
  end

endmodule

@@ rtl/nqsc_ctrl.sv @@
module nqsc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  nqsc_pkg::dp_status_t status,
  output nqsc_pkg::dp_cmd_t    cmd
);
  import nqsc_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = status.init_final ? ST_FINISH : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.search_last) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // The result register frees up in the same cycle its transaction completes.
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ rtl/n_queens_solution_counter_core.sv @@
// N-queens solution counter. Each input transaction gives the column of the
// first-row queen; the block runs a depth-first backtracking search over the
// remaining rows and returns one result transaction with the number of full
// placements for that column (saturating), or column_invalid set and a zero
// count when the column is not on the board. Add the results of all columns
// to get the board total. board_size is written through the cfg port; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. Values above MAX_BOARD act as MAX_BOARD, and zero makes every
// column invalid. The search takes one step (one column tried, or one queen
// lifted on backtrack) per clock, after setup and before hand-off of the result.
// An off-board column or a 1x1 board skips the search. A new item is taken once
// the previous search has handed its result to the output register, even while
// that result still waits to be taken.
module n_queens_solution_counter_core #(
  parameter int MAX_BOARD  = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nqsc_pkg::BOARD_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [nqsc_pkg::COLUMN_W-1:0]    first_column,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nqsc_pkg::OUT_COUNT_W-1:0] solution_count,
  output logic                             column_invalid
);
  import nqsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  nqsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  nqsc_datapath #(
    .MAX_BOARD  (MAX_BOARD),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .first_column_in (first_column),
    .cmd             (cmd),
    .status          (status),
    .solution_count  (solution_count),
    .column_invalid  (column_invalid)
  );

endmodule

@@ test/n_queens_solution_counter_core_tb.sv @@
module n_queens_solution_counter_core_tb;

  localparam int BOARD_LIMIT = 16;
  localparam int IDLE_LIMIT  = 400000;

  typedef logic [nqsc_pkg::BOARD_W-1:0]     board_t;
  typedef logic [nqsc_pkg::COLUMN_W-1:0]    column_t;
  typedef logic [nqsc_pkg::OUT_COUNT_W-1:0] count_t;

  typedef struct {
    count_t count;
    logic   off_board;
  } tally_t;

  class queens_scoreboard;
    board_t board_size = nqsc_pkg::BOARD_RESET;
    tally_t awaited_tallies[$];
    int     errors = 0;

    function void set_board(board_t size);
      board_size = size;
    endfunction

    function int pending();
      return awaited_tallies.size();
    endfunction

    // Depth-first search with bit masks for columns and both diagonals.
    // The queen of the last row is counted but never marked.
    function tally_t count_placements(column_t first);
      tally_t          t;
      int unsigned     n;
      int unsigned     row;
      int unsigned     c;
      int unsigned     queen[BOARD_LIMIT];
      bit [31:0]       cols_used;
      bit [31:0]       rising_used;
      bit [31:0]       falling_used;
      longint unsigned total;
      n = (board_size > BOARD_LIMIT) ? BOARD_LIMIT : board_size;
      total = 0;
      t.off_board = 1'b0;
      if (first >= n) begin
        t.off_board = 1'b1;
        t.count = '0;
        return t;
      end
      if (n == 1) begin
        total = 1;
      end else begin
        queen[0] = first;
        cols_used = 32'd1 << first;
        rising_used = 32'd1 << first;
        falling_used = 32'd1 << (15 - first);
        row = 1;
        c = 0;
        while (row >= 1) begin
          if (c >= n) begin
            row = row - 1;
            if (row == 0)
              break;
            c = queen[row];
            cols_used[c] = 1'b0;
            rising_used[row + c] = 1'b0;
            falling_used[row + 15 - c] = 1'b0;
            c = c + 1;
          end else if (!cols_used[c] && !rising_used[row + c] &&
                       !falling_used[row + 15 - c]) begin
            if (row == n - 1) begin
              total++;
              c = c + 1;
            end else begin
              queen[row] = c;
              cols_used[c] = 1'b1;
              rising_used[row + c] = 1'b1;
              falling_used[row + 15 - c] = 1'b1;
              row = row + 1;
              c = 0;
            end
          end else begin
            c = c + 1;
          end
        end
      end
      if (total > {nqsc_pkg::OUT_COUNT_W{1'b1}})
        t.count = '1;
      else
        t.count = total[nqsc_pkg::OUT_COUNT_W-1:0];
      return t;
    endfunction

    function void note_column(column_t first);
      awaited_tallies.push_back(count_placements(first));
    endfunction

    function void check_result(count_t count, logic off_board);
      tally_t t;
      if (awaited_tallies.size() == 0) begin
        $display("%0t: result with no column waiting, got count %0d invalid %0b",
                 $time, count, off_board);
        errors++;
        return;
      end
      t = awaited_tallies.pop_front();
      if (count !== t.count) begin
        $display("%0t: solution_count mismatch, expected %0d, got %0d",
                 $time, t.count, count);
        errors++;
      end
      if (off_board !== t.off_board) begin
        $display("%0t: column_invalid mismatch, expected %0b, got %0b",
                 $time, t.off_board, off_board);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  board_t  cfg_data = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  column_t first_column = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  count_t  solution_count;
  logic    column_invalid;

  queens_scoreboard sb = new;

  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int stall_left = 0;
  int stall_len;
  int idle_cycles = 0;

  n_queens_solution_counter_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_column   (first_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .solution_count (solution_count),
    .column_invalid (column_invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 9);
    if (r < 5)
      return 0;
    if (r < 9)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic board_t pick_board();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    if (r < 60)
      return board_t'($urandom_range(1, 7));
    if (r < 92)
      return board_t'(8);
    return board_t'(9);
  endfunction

  // Most columns land on the board; the rest may fall off it.
  function automatic column_t pick_column(board_t size);
    int n;
    n = (size > BOARD_LIMIT) ? BOARD_LIMIT : size;
    if (n == 0 || $urandom_range(0, 3) == 0)
      return column_t'($urandom_range(0, 15));
    return column_t'($urandom_range(0, n - 1));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(solution_count, column_invalid);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        stall_len = pick_gap(quiet_out);
        out_stall <= (stall_len > 0);
        stall_left <= (stall_len > 0) ? stall_len - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Leaves in_valid high after acceptance so that a following transaction
  // with no gap keeps it high without a second assignment in one step.
  task automatic send_column(input column_t col);
    int gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_column <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_column(col);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_board(input board_t size);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_board(size);
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    board_t size;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Board size straight out of reset, with columns on and off the board.
    send_column(column_t'(0));
    send_column(column_t'(7));
    drain();
    send_column(column_t'(8));
    send_column(column_t'(15));

    // A single square, then an empty board.
    write_board(board_t'(1));
    send_column(column_t'(0));
    send_column(column_t'(1));
    send_column(column_t'(15));
    write_board(board_t'(0));
    send_column(column_t'(0));
    send_column(column_t'(15));

    // Full-size boards are not searched here, so the largest setting
    // only goes through the register port.
    write_board('1);
    write_board(board_t'(2));
    send_column(column_t'(0));
    send_column(column_t'(1));
    send_column(column_t'(2));
    write_board(board_t'(3));
    send_column(column_t'(0));
    send_column(column_t'(1));
    send_column(column_t'(2));
    write_board(board_t'(4));
    for (int c = 0; c < 4; c++)
      send_column(column_t'(c));
    write_board(board_t'(10));
    send_column(column_t'(0));
    send_column(column_t'(5));
    send_column(column_t'(9));
    send_column(column_t'(10));

    sent = 0;
    while (sent < 75) begin
      size = pick_board();
      write_board(size);
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(4, 14);
      for (int i = 0; i < burst; i++) begin
        if (i == burst / 2 && $urandom_range(0, 3) == 0)
          drain();
        send_column(pick_column(size));
        sent++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
